// File: rtl/core/sic_pkg.sv
package sic_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } opcode_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DZ    = 2'd3;

  typedef struct packed {
    logic    start;
    opcode_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

// File: rtl/core/sic_if.sv
interface sic_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface sic_out_if #(
  parameter int unsigned DEPTH_W = 5
);
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic [1:0]         status;
  logic [DEPTH_W-1:0] depth;

  modport source (output valid, output result, output status, output depth, input ready);
  modport sink (input valid, input result, input status, input depth, output ready);
endinterface

// File: rtl/core/sic_stack.sv
module sic_stack #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sic_alu.sv
module sic_alu
  import sic_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alu_req_t          req_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output alu_rsp_t          rsp_o,
  output logic [WORD_W-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_NEGA,
    A_NEGB,
    A_DIV,
    A_NEGQ,
    A_DONE
  } alu_state_e;

  alu_state_e        state_q, state_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] opa_q, opa_d;
  logic [WORD_W-1:0] opb_q, opb_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              dz_q, dz_d;

  logic [WORD_W-1:0] add_x, add_y;
  logic              add_sub;
  logic [WORD_W:0]   add_sum;
  logic [WORD_W-1:0] rem_sh;

  assign rem_sh = {acc_q[WORD_W-2:0], opa_q[WORD_W-1]};

  // The one shared adder. In subtract mode the carry out means x >= y.
  always_comb begin
    unique case (state_q)
      A_IDLE: begin
        add_x   = a_i;
        add_y   = b_i;
        add_sub = (req_i.op == OP_SUB);
      end
      A_MUL: begin
        add_x   = acc_q;
        add_y   = opa_q;
        add_sub = 1'b0;
      end
      A_NEGA: begin
        add_x   = '0;
        add_y   = opa_q;
        add_sub = 1'b1;
      end
      A_NEGB: begin
        add_x   = '0;
        add_y   = opb_q;
        add_sub = 1'b1;
      end
      A_DIV: begin
        add_x   = rem_sh;
        add_y   = opb_q;
        add_sub = 1'b1;
      end
      A_NEGQ: begin
        add_x   = '0;
        add_y   = opa_q;
        add_sub = 1'b1;
      end
      A_DONE: begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
      end
      default: begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                 + {{WORD_W{1'b0}}, add_sub};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dz_d    = dz_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          dz_d = 1'b0;
          unique case (req_i.op) inside
            OP_ADD, OP_SUB: begin
              acc_d   = add_sum[WORD_W-1:0];
              state_d = A_DONE;
            end
            OP_MUL: begin
              acc_d   = '0;
              opa_d   = a_i;
              opb_d   = b_i;
              cnt_d   = '0;
              state_d = A_MUL;
            end
            OP_DIV: begin
              if (b_i == '0) begin
                acc_d   = '0;
                dz_d    = 1'b1;
                state_d = A_DONE;
              end else begin
                opa_d   = a_i;
                opb_d   = b_i;
                neg_d   = a_i[WORD_W-1] ^ b_i[WORD_W-1];
                state_d = A_NEGA;
              end
            end
            default: begin
              acc_d   = '0;
              state_d = A_DONE;
            end
          endcase
        end
      end
      A_MUL: begin
        if (opb_q[0]) begin
          acc_d = add_sum[WORD_W-1:0];
        end
        opa_d = {opa_q[WORD_W-2:0], 1'b0};
        opb_d = {1'b0, opb_q[WORD_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = A_DONE;
        end
      end
      A_NEGA: begin
        if (opa_q[WORD_W-1]) begin
          opa_d = add_sum[WORD_W-1:0];
        end
        state_d = A_NEGB;
      end
      A_NEGB: begin
        if (opb_q[WORD_W-1]) begin
          opb_d = add_sum[WORD_W-1:0];
        end
        acc_d   = '0;
        cnt_d   = '0;
        state_d = A_DIV;
      end
      A_DIV: begin
        acc_d = add_sum[WORD_W] ? add_sum[WORD_W-1:0] : rem_sh;
        opa_d = {opa_q[WORD_W-2:0], add_sum[WORD_W]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = A_NEGQ;
        end
      end
      A_NEGQ: begin
        acc_d   = neg_q ? add_sum[WORD_W-1:0] : opa_q;
        state_d = A_DONE;
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
  end

  assign rsp_o.done     = (state_q == A_DONE);
  assign rsp_o.div_zero = dz_q;
  assign result_o       = acc_q;

endmodule

// File: rtl/core/stack_integer_calculator.sv
// Push goes from decode straight to the output register; add, subtract, multiply and
// divide pop two operands, run them through the ALU and push the result.
// Multiply and divide work one bit per cycle through the shared adder;
// a divide by zero skips the bit loop. One item is in flight at a time;
// a result still waiting in the output register holds the next one back.
// Reset is asynchronous and active low; it empties the stack and drops any pending result.
module stack_integer_calculator
  import sic_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sic_in_if.sink           in_i,
  sic_out_if.source        out_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POPA,
    S_POPB,
    S_START,
    S_EXEC,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        op_q, op_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] b_q, b_d;
  logic              a_hit_q, a_hit_d;
  logic              b_hit_q, b_hit_d;
  logic              under_q, under_d;
  logic [WORD_W-1:0] res_q, res_d;
  logic [1:0]        status_q, status_d;
  logic [WORD_W-1:0] out_result_q, out_result_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [CW-1:0]     out_depth_q, out_depth_d;

  logic [CW-1:0]     count_dec;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [WORD_W-1:0] alu_result;

  assign count_dec = count_q - CW'(1);

  sic_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (count_dec[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  sic_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (a_q),
    .b_i      (b_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    op_d         = op_q;
    val_d        = val_q;
    a_d          = a_q;
    b_d          = b_q;
    a_hit_d      = a_hit_q;
    b_hit_d      = b_hit_q;
    under_d      = under_q;
    res_d        = res_q;
    status_d     = status_q;
    out_result_d = out_result_q;
    out_status_d = out_status_q;
    out_depth_d  = out_depth_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[AW-1:0];
    mem_wdata    = val_q;
    alu_req      = '{start: 1'b0, op: opcode_e'(op_q)};
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.opcode;
          val_d   = in_i.value;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_q) inside
          OP_PUSH: begin
            res_d = val_q;
            if (count_q < FULL) begin
              mem_we   = 1'b1;
              count_d  = count_q + CW'(1);
              status_d = ST_OK;
            end else begin
              status_d = ST_OVF;
            end
            state_d = S_OUT;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            a_hit_d = (count_q != '0);
            if (count_q != '0) begin
              count_d = count_dec;
            end
            state_d = S_POPA;
          end
          default: begin
            res_d    = '0;
            status_d = ST_OK;
            state_d  = S_OUT;
          end
        endcase
      end
      S_POPA: begin
        a_d     = a_hit_q ? mem_rdata : '1;
        b_hit_d = (count_q != '0);
        if (count_q != '0) begin
          count_d = count_dec;
        end
        state_d = S_POPB;
      end
      S_POPB: begin
        b_d     = b_hit_q ? mem_rdata : '1;
        under_d = !(a_hit_q && b_hit_q);
        state_d = S_START;
      end
      S_START: begin
        alu_req.start = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          res_d     = alu_result;
          mem_wdata = alu_result;
          if (under_q) begin
            status_d = ST_UNDER;
          end else if (alu_rsp.div_zero) begin
            status_d = ST_DZ;
          end else if (count_q >= FULL) begin
            status_d = ST_OVF;
          end else begin
            status_d = ST_OK;
          end
          if (count_q < FULL) begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_result_d = res_q;
          out_status_d = status_q;
          out_depth_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    a_q          <= a_d;
    b_q          <= b_d;
    a_hit_q      <= a_hit_d;
    b_hit_q      <= b_hit_d;
    under_q      <= under_d;
    res_q        <= res_d;
    status_q     <= status_d;
    out_result_q <= out_result_d;
    out_status_q <= out_status_d;
    out_depth_q  <= out_depth_d;
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_result_q;
  assign out_o.status = out_status_q;
  assign out_o.depth  = out_depth_q;

endmodule

// File: rtl/core/sic_checker.sv
module sic_checker
  import sic_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [31:0]                        out_result_i,
  input logic [1:0]                         out_status_i,
  input logic [$clog2(STACK_DEPTH + 1)-1:0] out_depth_i
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // The block works on one item at a time, so it is busy right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_depth_i <= FULL)
    else $error("reported depth exceeds the stack size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_OVF |-> out_depth_i == FULL)
    else $error("overflow reported while the stack is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_UNDER |-> out_depth_i == CW'(1))
    else $error("underflow must leave exactly the pushed result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_i))
    else $error("stalled result changed");

endmodule

bind stack_integer_calculator sic_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_sic_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result),
  .out_status_i (out_o.status),
  .out_depth_i  (out_o.depth)
);
